### hdl/ksa_pkg.sv
// ----------------------------------------------------------------------------
// Keyed statistics accumulator package
// Field widths, operation codes and the structures passed between the cells
// of the chain and the result stage.
// ----------------------------------------------------------------------------
package ksa_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned INC_W   = 32;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned RSUM_W  = 64;

  localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] function_address;
    logic [INC_W-1:0]  calls_increment;
    logic [INC_W-1:0]  inclusive_increment;
    logic [INC_W-1:0]  exclusive_increment;
    logic              last_in_batch;
    logic [IDX_W-1:0]  entry_index;
    logic              done;
    logic              new_entry;
    logic              read_valid;
    logic [ADDR_W-1:0] read_address;
    logic [RSUM_W-1:0] read_calls;
    logic [RSUM_W-1:0] read_inclusive;
    logic [RSUM_W-1:0] read_exclusive;
  } ksa_tok_t;

  typedef struct packed {
    logic               new_entry;
    logic               batch_inserted;
    logic               table_full;
    logic [COUNT_W-1:0] entry_count;
    logic               read_valid;
    logic [ADDR_W-1:0]  read_address;
    logic [RSUM_W-1:0]  read_calls;
    logic [RSUM_W-1:0]  read_inclusive;
    logic [RSUM_W-1:0]  read_exclusive;
  } ksa_res_t;

endpackage

### hdl/ksa_in_if.sv
// ----------------------------------------------------------------------------
// Keyed statistics accumulator input channel
// Valid/ready channel carrying one operation per transaction.
// ----------------------------------------------------------------------------
interface ksa_in_if;
  logic                        valid;
  logic                        ready;
  logic [ksa_pkg::OP_W-1:0]    op;
  logic [ksa_pkg::ADDR_W-1:0]  function_address;
  logic [ksa_pkg::INC_W-1:0]   calls_increment;
  logic [ksa_pkg::INC_W-1:0]   inclusive_increment;
  logic [ksa_pkg::INC_W-1:0]   exclusive_increment;
  logic                        last_in_batch;
  logic [ksa_pkg::IDX_W-1:0]   entry_index;

  modport source (
    output valid, op, function_address, calls_increment, inclusive_increment,
           exclusive_increment, last_in_batch, entry_index,
    input  ready
  );

  modport sink (
    input  valid, op, function_address, calls_increment, inclusive_increment,
           exclusive_increment, last_in_batch, entry_index,
    output ready
  );
endinterface

### hdl/ksa_out_if.sv
// ----------------------------------------------------------------------------
// Keyed statistics accumulator output channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface ksa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         new_entry;
  logic                         batch_inserted;
  logic                         table_full;
  logic [ksa_pkg::COUNT_W-1:0]  entry_count;
  logic                         read_valid;
  logic [ksa_pkg::ADDR_W-1:0]   read_address;
  logic [ksa_pkg::RSUM_W-1:0]   read_calls;
  logic [ksa_pkg::RSUM_W-1:0]   read_inclusive;
  logic [ksa_pkg::RSUM_W-1:0]   read_exclusive;

  modport source (
    output valid, new_entry, batch_inserted, table_full, entry_count, read_valid,
           read_address, read_calls, read_inclusive, read_exclusive,
    input  ready
  );

  modport sink (
    input  valid, new_entry, batch_inserted, table_full, entry_count, read_valid,
           read_address, read_calls, read_inclusive, read_exclusive,
    output ready
  );
endinterface

### hdl/ksa_cell.sv
// ----------------------------------------------------------------------------
// Keyed statistics accumulator cell
// Holds one entry at a fixed insertion rank. Each transaction is registered as
// it passes through the cell and may match, create, read or clear the entry.
// ----------------------------------------------------------------------------
module ksa_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned SUM_BITS   = 64,
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              vld_i,
  input  ksa_pkg::ksa_tok_t tok_i,
  output logic              vld_o,
  output ksa_pkg::ksa_tok_t tok_o
);
  import ksa_pkg::*;

  logic                vld_q;
  ksa_tok_t            tok_q;
  ksa_tok_t            tok_d;
  logic                used_q;
  logic                used_d;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_d;
  logic [SUM_BITS-1:0] calls_q;
  logic [SUM_BITS-1:0] calls_d;
  logic [SUM_BITS-1:0] incl_q;
  logic [SUM_BITS-1:0] incl_d;
  logic [SUM_BITS-1:0] excl_q;
  logic [SUM_BITS-1:0] excl_d;
  logic [KEY_BITS-1:0] tok_key;
  logic                key_hit;
  logic                idx_hit;

  assign tok_key = KEY_BITS'(tok_i.function_address);
  assign key_hit = used_q && (key_q == tok_key);
  assign idx_hit = (32'(tok_i.entry_index) == CELL_INDEX);

  always_comb begin
    tok_d   = tok_i;
    used_d  = used_q;
    key_d   = key_q;
    calls_d = calls_q;
    incl_d  = incl_q;
    excl_d  = excl_q;
    case (tok_i.op)
      OP_ACCUM: begin
        if (!tok_i.done) begin
          if (key_hit) begin
            calls_d    = calls_q + SUM_BITS'(tok_i.calls_increment);
            incl_d     = incl_q + SUM_BITS'(tok_i.inclusive_increment);
            excl_d     = excl_q + SUM_BITS'(tok_i.exclusive_increment);
            tok_d.done = 1'b1;
          end else if (!used_q) begin
            used_d          = 1'b1;
            key_d           = tok_key;
            calls_d         = SUM_BITS'(tok_i.calls_increment);
            incl_d          = SUM_BITS'(tok_i.inclusive_increment);
            excl_d          = SUM_BITS'(tok_i.exclusive_increment);
            tok_d.done      = 1'b1;
            tok_d.new_entry = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (used_q && idx_hit) begin
          tok_d.read_valid     = 1'b1;
          tok_d.read_address   = ADDR_W'(key_q);
          tok_d.read_calls     = RSUM_W'(calls_q);
          tok_d.read_inclusive = RSUM_W'(incl_q);
          tok_d.read_exclusive = RSUM_W'(excl_q);
        end
      end
      OP_CLEAR: begin
        used_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      used_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
      if (vld_i) begin
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      if (vld_i) begin
        key_q   <= key_d;
        calls_q <= calls_d;
        incl_q  <= incl_d;
        excl_q  <= excl_d;
      end
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

### hdl/ksa_exit.sv
// ----------------------------------------------------------------------------
// Keyed statistics accumulator result stage
// Keeps the entry count and the batch flag, forms each result and holds it in
// the output register until the transaction completes.
// ----------------------------------------------------------------------------
module ksa_exit #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  ksa_pkg::ksa_tok_t tok_i,
  input  logic              out_ready_i,
  output logic              adv_o,
  output logic              out_valid_o,
  output ksa_pkg::ksa_res_t res_o
);
  import ksa_pkg::*;

  localparam int unsigned CountW = $clog2(ENTRIES + 1);

  logic              out_vld_q;
  ksa_res_t          res_q;
  ksa_res_t          res_d;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic              seen_q;
  logic              seen_d;
  logic              seen_after;

  assign adv_o      = !out_vld_q || out_ready_i;
  assign seen_after = seen_q || tok_i.new_entry;

  always_comb begin
    res_d   = '0;
    count_d = count_q;
    seen_d  = seen_q;
    case (tok_i.op)
      OP_ACCUM: begin
        res_d.new_entry  = tok_i.new_entry;
        res_d.table_full = !tok_i.done;
        if (tok_i.new_entry) begin
          count_d = count_q + CountW'(1);
        end
        if (tok_i.last_in_batch) begin
          res_d.batch_inserted = seen_after;
          seen_d               = 1'b0;
        end else begin
          seen_d = seen_after;
        end
      end
      OP_READ: begin
        res_d.read_valid     = tok_i.read_valid;
        res_d.read_address   = tok_i.read_address;
        res_d.read_calls     = tok_i.read_calls;
        res_d.read_inclusive = tok_i.read_inclusive;
        res_d.read_exclusive = tok_i.read_exclusive;
      end
      OP_CLEAR: begin
        count_d = '0;
        seen_d  = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.entry_count = COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      count_q   <= '0;
      seen_q    <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= vld_i;
      if (vld_i) begin
        count_q <= count_d;
        seen_q  <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && vld_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(ENTRIES))
    else $error("Entry count exceeds the table size.");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.table_full) |-> (count_q == CountW'(ENTRIES)))
    else $error("Table full reported while a slot was free.");

  a_new_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.new_entry) |-> (!res_q.table_full && !res_q.read_valid))
    else $error("New entry flagged together with full or read result.");
`endif

endmodule

### hdl/keyed_stats_accumulator.sv
// Each accepted transaction passes every cell's register, then the output register.
// Throughput: one transaction per cycle unless stalled; each cell updates its
// entry as the transaction passes, so the next one already sees the new sums.
// The whole chain stalls while a result waits in the output register.
// Reset empties the table at once through per-cell used flags; no clearing pass.
// ----------------------------------------------------------------------------
// Keyed statistics accumulator
// Per-key call and time statistics held in a chain of cells in insertion order,
// with accumulate, read by rank and clear operations.
// ----------------------------------------------------------------------------
module keyed_stats_accumulator #(
  parameter int unsigned ENTRIES  = 256,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned SUM_BITS = 64
) (
  input logic     clk_i,
  input logic     rst_ni,
  ksa_in_if.sink  in_i,
  ksa_out_if.source out_o
);
  import ksa_pkg::*;

  logic     adv;
  logic     out_vld;
  ksa_res_t res;
  logic     chain_vld [ENTRIES+1];
  ksa_tok_t chain_tok [ENTRIES+1];

  assign in_i.ready   = adv;
  assign chain_vld[0] = in_i.valid;

  always_comb begin
    chain_tok[0]                     = '0;
    chain_tok[0].op                  = in_i.op;
    chain_tok[0].function_address    = in_i.function_address;
    chain_tok[0].calls_increment     = in_i.calls_increment;
    chain_tok[0].inclusive_increment = in_i.inclusive_increment;
    chain_tok[0].exclusive_increment = in_i.exclusive_increment;
    chain_tok[0].last_in_batch       = in_i.last_in_batch;
    chain_tok[0].entry_index         = in_i.entry_index;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ksa_cell #(
      .KEY_BITS   (KEY_BITS),
      .SUM_BITS   (SUM_BITS),
      .CELL_INDEX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (chain_vld[g]),
      .tok_i  (chain_tok[g]),
      .vld_o  (chain_vld[g+1]),
      .tok_o  (chain_tok[g+1])
    );
  end

  ksa_exit #(
    .ENTRIES (ENTRIES)
  ) u_exit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (chain_vld[ENTRIES]),
    .tok_i       (chain_tok[ENTRIES]),
    .out_ready_i (out_o.ready),
    .adv_o       (adv),
    .out_valid_o (out_vld),
    .res_o       (res)
  );

  assign out_o.valid          = out_vld;
  assign out_o.new_entry      = res.new_entry;
  assign out_o.batch_inserted = res.batch_inserted;
  assign out_o.table_full     = res.table_full;
  assign out_o.entry_count    = res.entry_count;
  assign out_o.read_valid     = res.read_valid;
  assign out_o.read_address   = res.read_address;
  assign out_o.read_calls     = res.read_calls;
  assign out_o.read_inclusive = res.read_inclusive;
  assign out_o.read_exclusive = res.read_exclusive;

endmodule
